>>> sv/partial_binomial_coefficient_sum_assert.svh
// assertion macros shared by the partial binomial coefficient sum modules
`ifndef PARTIAL_BINOMIAL_COEFFICIENT_SUM_ASSERT_SVH
`define PARTIAL_BINOMIAL_COEFFICIENT_SUM_ASSERT_SVH

`ifndef SYNTHESIS

`define PBCS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

`define PBCS_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define PBCS_ASSERT(lbl, clk, rstn, prop)

`define PBCS_ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

>>> sv/pbcs_pkg.sv
// types and constants of the partial binomial coefficient sum block
`timescale 1ns / 1ps

package pbcs_pkg;

  localparam int unsigned FieldWidth = 6;
  localparam int unsigned WordWidth  = 64;
  localparam int unsigned SumWidth   = 63;
  localparam logic [FieldWidth-1:0] MaxTrials = 6'd62;

  typedef struct packed {
    logic [FieldWidth-1:0] trial_count;
    logic [FieldWidth-1:0] upper_term;
  } req_t;

  typedef struct packed {
    logic [SumWidth-1:0] coefficient_sum;
    logic                bad_request;
  } res_t;

  typedef struct packed {
    logic                  start;
    logic [WordWidth-1:0]  dividend;
    logic [FieldWidth-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic                 busy;
    logic [WordWidth-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StAcc,
    StMul,
    StLaunch,
    StWait,
    StFinish
  } state_e;

endpackage

>>> sv/partial_binomial_coefficient_sum.sv
// top level: sequencer for the partial sum of binomial coefficients
//
//   channel   direction  ports                        handshake
//   request   in         start, busy, req_i           taken when start && !busy
//   result    out        result_valid_o, res_o        one-cycle strobe, no stall
//
// a valid request (n, k) runs one term per step of i from 0 up to k, from acceptance to the strobe:
// each term costs an add, a multiply, a divider launch and a wait on the serial divider
// a rejected request gives its strobe in the cycle after acceptance
// busy rises once a request is accepted and stays high up to and including the strobe cycle
// reset clears the sequencer and the divider control, no clearing pass
// the result receiver cannot stall, results are never held back
`timescale 1ns / 1ps
`include "partial_binomial_coefficient_sum_assert.svh"

module partial_binomial_coefficient_sum (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  pbcs_pkg::req_t req_i,
  output logic           result_valid_o,
  output pbcs_pkg::res_t res_o
);

  localparam int unsigned W  = pbcs_pkg::WordWidth;
  localparam int unsigned SW = pbcs_pkg::SumWidth;
  localparam int unsigned FW = pbcs_pkg::FieldWidth;

  pbcs_pkg::state_e state_q, state_d;

  logic [FW-1:0] n_q, n_d;
  logic [FW-1:0] k_q, k_d;
  logic [FW-1:0] i_q, i_d;
  logic [W-1:0]  c_q, c_d;
  logic [W-1:0]  prod_q, prod_d;
  logic [SW-1:0] sum_q, sum_d;
  logic          bad_q, bad_d;
  logic          bad_req;

  pbcs_pkg::div_req_t div_req;
  pbcs_pkg::div_rsp_t div_rsp;

  pbcs_divider u_divider (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign bad_req = (req_i.trial_count == '0) || (req_i.upper_term > req_i.trial_count) ||
                   (req_i.trial_count > pbcs_pkg::MaxTrials);

  always_comb begin
    state_d          = state_q;
    n_d              = n_q;
    k_d              = k_q;
    i_d              = i_q;
    c_d              = c_q;
    prod_d           = prod_q;
    sum_d            = sum_q;
    bad_d            = bad_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = i_q + 1'b1;
    case (state_q)
      pbcs_pkg::StIdle: begin
        if (start) begin
          n_d   = req_i.trial_count;
          k_d   = req_i.upper_term;
          i_d   = '0;
          c_d   = W'(1);
          sum_d = '0;
          bad_d = bad_req;
          state_d = bad_req ? pbcs_pkg::StFinish : pbcs_pkg::StAcc;
        end
      end
      pbcs_pkg::StAcc: begin
        sum_d   = sum_q + c_q[SW-1:0];
        state_d = (i_q == k_q) ? pbcs_pkg::StFinish : pbcs_pkg::StMul;
      end
      pbcs_pkg::StMul: begin
        prod_d  = W'(c_q * W'(n_q - i_q));
        state_d = pbcs_pkg::StLaunch;
      end
      pbcs_pkg::StLaunch: begin
        div_req.start = 1'b1;
        state_d       = pbcs_pkg::StWait;
      end
      pbcs_pkg::StWait: begin
        if (div_rsp.done) begin
          c_d     = div_rsp.quotient;
          i_d     = i_q + 1'b1;
          state_d = pbcs_pkg::StAcc;
        end
      end
      pbcs_pkg::StFinish: begin
        state_d = pbcs_pkg::StIdle;
      end
      default: begin
        state_d = pbcs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbcs_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    k_q    <= k_d;
    i_q    <= i_d;
    c_q    <= c_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    bad_q  <= bad_d;
  end

  assign busy                  = state_q != pbcs_pkg::StIdle;
  assign result_valid_o        = state_q == pbcs_pkg::StFinish;
  assign res_o.coefficient_sum = sum_q;
  assign res_o.bad_request     = bad_q;

  `PBCS_ASSERT(a_accept_goes_busy, clk_i, rst_ni, start && !busy |=> busy)
  `PBCS_ASSERT_NEVER(a_bad_gives_zero, clk_i, rst_ni, result_valid_o && bad_q && sum_q != '0)
  `PBCS_ASSERT_NEVER(a_idle_div_busy, clk_i, rst_ni, !busy && div_rsp.busy)

endmodule

>>> sv/pbcs_divider.sv
// serial restoring divider, one quotient bit per cycle, small divisor
`timescale 1ns / 1ps
`include "partial_binomial_coefficient_sum_assert.svh"

module pbcs_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pbcs_pkg::div_req_t req_i,
  output pbcs_pkg::div_rsp_t rsp_o
);

  localparam int unsigned W  = pbcs_pkg::WordWidth;
  localparam int unsigned DW = pbcs_pkg::FieldWidth;
  localparam int unsigned CW = $clog2(W);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] divisor_q, divisor_d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  always_comb begin
    trial     = {rem_q, quo_q[W-1]};
    diff      = trial - {1'b0, divisor_q};
    fits      = trial >= {1'b0, divisor_q};
    busy_d    = busy_q;
    done_d    = 1'b0;
    cnt_d     = cnt_q;
    quo_d     = quo_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    if (req_i.start && !busy_q) begin
      busy_d    = 1'b1;
      cnt_d     = CW'(W - 1);
      quo_d     = req_i.dividend;
      rem_d     = '0;
      divisor_d = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[W-2:0], fits};
      rem_d = fits ? diff[DW-1:0] : trial[DW-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q     <= quo_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.busy     = busy_q;
  assign rsp_o.quotient = quo_q;

  `PBCS_ASSERT(a_last_bit_done, clk_i, rst_ni, busy_q && cnt_q == '0 |=> done_q && !busy_q)
  `PBCS_ASSERT(a_done_after_busy, clk_i, rst_ni, done_q |-> $past(busy_q))
  `PBCS_ASSERT(a_rem_below_divisor, clk_i, rst_ni, busy_q |-> rem_q < divisor_q)

endmodule
